>>> sv/sktis_pkg.sv
// Shared types and constants of the sorted key table.
`default_nettype none

package sktis_pkg;

    localparam int KEY_W     = 64;
    localparam int TOTAL_W   = 64;
    localparam int COUNT_W   = 7;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Operation codes carried on the opcode port.
    localparam logic OP_SEARCH = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WRITES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLUSHES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FENCES  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] WRITES_RST  = 4'd4;
    localparam logic [CFG_W-1:0] FLUSHES_RST = 4'd2;
    localparam logic [CFG_W-1:0] FENCES_RST  = 4'd1;

    typedef enum logic
    {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } state_t;

    // What one cell shows to the cell above it.
    typedef struct packed
    {
        logic [KEY_W-1:0] key;
        logic             ge;
        logic             valid;
    } link_t;

endpackage

`default_nettype wire

>>> sv/sktis_cell.sv
// One slot of the sorted key table: stored key, compare flags and shift logic.
`default_nettype none

module sktis_cell
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmp_en,
    input  wire logic                        ins_en,
    input  wire logic [sktis_pkg::KEY_W-1:0] cmp_key,
    input  wire logic [sktis_pkg::KEY_W-1:0] ins_key,
    input  wire sktis_pkg::link_t            prev,
    output sktis_pkg::link_t                 cur,
    output logic                             eq
);

    logic [sktis_pkg::KEY_W-1:0] key_reg;
    logic [sktis_pkg::KEY_W-1:0] key_next;
    logic                        valid_reg;
    logic                        ge_reg;
    logic                        eq_reg;
    logic                        take_new;

    // The new key lands here when this slot is the first one not below it,
    // or when this is the first empty slot and no stored key is above it.
    assign take_new = ge_reg || (!valid_reg && prev.valid);

    always_comb
    begin
        key_next = key_reg;
        if (prev.ge)
        begin
            key_next = prev.key;
        end
        else if (take_new)
        begin
            key_next = ins_key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            key_reg <= key_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ge_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            if (cmp_en)
            begin
                ge_reg <= valid_reg && (key_reg >= cmp_key);
                eq_reg <= valid_reg && (key_reg == cmp_key);
            end
            if (ins_en)
            begin
                valid_reg <= valid_reg | prev.valid;
            end
        end
    end

    assign cur.key   = key_reg;
    assign cur.ge    = ge_reg;
    assign cur.valid = valid_reg;
    assign eq        = eq_reg;

endmodule

`default_nettype wire

>>> sv/sorted_key_table_insert_search.sv
// Top level of the sorted key table: control, cost totals and the row of cells.
//
//   Channel    Handshake           Payload
//   ---------  ------------------  ------------------------------------------------
//   command    start / busy        opcode, key
//   result     done (one cycle)    found, table_full, stored_count, write_count,
//                                  flush_count, fence_count
//   config     cfg_we              cfg_index, cfg_data
//
// Each transaction has an accept cycle and an update cycle. In the accept cycle each
// cell compares its stored key with the incoming key and registers the outcome, and in
// the following cycle the cells shift and take the new key in parallel (on an insert
// that the table takes) while the result registers load. The result strobe done is
// high in the cycle after that, and start may already be taken again in that same
// cycle, so a transaction can be accepted while the last result is shown, but never
// in an update cycle. Reset clears the cells' valid flags, the occupancy and the totals,
// and restores the cost registers; the stored keys themselves are not reset. The receiver
// cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module sorted_key_table_insert_search
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                opcode,
    input  wire logic [sktis_pkg::KEY_W-1:0]         key,
    output logic                                     done,
    output logic                                     found,
    output logic                                     table_full,
    output logic [sktis_pkg::COUNT_W-1:0]            stored_count,
    output logic [sktis_pkg::TOTAL_W-1:0]            write_count,
    output logic [sktis_pkg::TOTAL_W-1:0]            flush_count,
    output logic [sktis_pkg::TOTAL_W-1:0]            fence_count,
    input  wire logic                                cfg_we,
    input  wire logic [sktis_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sktis_pkg::CFG_W-1:0]         cfg_data
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    sktis_pkg::state_t state_reg;
    sktis_pkg::state_t state_next;

    logic                          accept;
    logic                          op_reg;
    logic [sktis_pkg::KEY_W-1:0]   key_reg;
    logic [OCC_W-1:0]              occ_reg;
    logic [OCC_W-1:0]              occ_next;
    logic [sktis_pkg::CFG_W-1:0]   writes_reg;
    logic [sktis_pkg::CFG_W-1:0]   flushes_reg;
    logic [sktis_pkg::CFG_W-1:0]   fences_reg;
    logic [sktis_pkg::TOTAL_W-1:0] write_tot_reg;
    logic [sktis_pkg::TOTAL_W-1:0] flush_tot_reg;
    logic [sktis_pkg::TOTAL_W-1:0] fence_tot_reg;
    logic [sktis_pkg::TOTAL_W-1:0] write_tot_next;
    logic [sktis_pkg::TOTAL_W-1:0] flush_tot_next;
    logic [sktis_pkg::TOTAL_W-1:0] fence_tot_next;
    logic                          done_reg;
    logic                          found_reg;
    logic                          full_reg;
    logic [sktis_pkg::COUNT_W-1:0] count_reg;
    logic                          is_full;
    logic                          do_insert;
    logic                          any_eq;

    sktis_pkg::link_t              links [CAPACITY+1];
    logic [CAPACITY-1:0]           eq_vec;
    logic [CAPACITY-1:0]           valid_vec;

    assign accept = start && !busy;

    // The table is full exactly when the topmost cell holds a key, since the
    // valid flags always fill from the bottom of the row.
    assign is_full   = links[CAPACITY].valid;
    assign do_insert = (state_reg == sktis_pkg::ST_UPDATE)
                       && (op_reg == sktis_pkg::OP_INSERT) && !is_full;
    assign any_eq    = |eq_vec;

    // Control state machine.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sktis_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        case (state_reg)
            sktis_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sktis_pkg::ST_UPDATE;
                end
            end
            sktis_pkg::ST_UPDATE:
            begin
                busy       = 1'b1;
                state_next = sktis_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sktis_pkg::ST_IDLE;
            end
        endcase
    end

    // The bottom cell sees a neighbour that is always occupied and never
    // at or above the key, so it takes the new key only when it is empty or not below it.
    assign links[0].key   = '0;
    assign links[0].ge    = 1'b0;
    assign links[0].valid = 1'b1;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sktis_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmp_en  (accept),
            .ins_en  (do_insert),
            .cmp_key (key),
            .ins_key (key_reg),
            .prev    (links[i]),
            .cur     (links[i+1]),
            .eq      (eq_vec[i])
        );
        assign valid_vec[i] = links[i+1].valid;
    end

    // Transaction payload held for the update cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= key;
        end
    end

    // Running totals only move on an insert that the table actually takes.
    always_comb
    begin
        occ_next       = occ_reg;
        write_tot_next = write_tot_reg;
        flush_tot_next = flush_tot_reg;
        fence_tot_next = fence_tot_reg;
        if (do_insert)
        begin
            occ_next       = occ_reg + OCC_W'(1);
            write_tot_next = write_tot_reg + sktis_pkg::TOTAL_W'(writes_reg);
            flush_tot_next = flush_tot_reg + sktis_pkg::TOTAL_W'(flushes_reg);
            fence_tot_next = fence_tot_reg + sktis_pkg::TOTAL_W'(fences_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            write_tot_reg <= '0;
            flush_tot_reg <= '0;
            fence_tot_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            write_tot_reg <= write_tot_next;
            flush_tot_reg <= flush_tot_next;
            fence_tot_reg <= fence_tot_next;
            done_reg      <= (state_reg == sktis_pkg::ST_UPDATE);
        end
    end

    // Result registers load in the update cycle and are shown with done.
    always_ff @(posedge clk)
    begin
        if (state_reg == sktis_pkg::ST_UPDATE)
        begin
            found_reg <= (op_reg == sktis_pkg::OP_SEARCH) && any_eq;
            full_reg  <= (op_reg == sktis_pkg::OP_INSERT) && is_full;
            count_reg <= sktis_pkg::COUNT_W'(occ_next);
        end
    end

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            writes_reg  <= sktis_pkg::WRITES_RST;
            flushes_reg <= sktis_pkg::FLUSHES_RST;
            fences_reg  <= sktis_pkg::FENCES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sktis_pkg::REG_WRITES:  writes_reg  <= cfg_data;
                sktis_pkg::REG_FLUSHES: flushes_reg <= cfg_data;
                sktis_pkg::REG_FENCES:  fences_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign found        = found_reg;
    assign table_full   = full_reg;
    assign stored_count = count_reg;
    assign write_count  = write_tot_reg;
    assign flush_count  = flush_tot_reg;
    assign fence_count  = fence_tot_reg;

`ifndef NO_ASSERTIONS
    // The number of occupied cells always matches the occupancy counter.
    a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == occ_reg)
        else $error("occupied cells disagree with occupancy");

    // Occupied cells form an unbroken run from the bottom of the row.
    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + CAPACITY'(1))) == '0)
        else $error("occupied cells are not contiguous");

    // A result appears in the cycle after an update cycle.
    a_done_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sktis_pkg::ST_UPDATE) |=> done)
        else $error("result strobe missing after update");

    // A refused insert leaves the write total and the occupancy unchanged.
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sktis_pkg::ST_UPDATE && op_reg == sktis_pkg::OP_INSERT && is_full)
        |=> $stable(write_tot_reg) && $stable(occ_reg))
        else $error("refused insert changed the table state");

    // A result never claims both a hit and a refused insert.
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(found && table_full))
        else $error("found and table_full both set");
`endif

endmodule

`default_nettype wire

>>> bench/sorted_key_table_insert_search_test.sv
// Self-checking testbench for the sorted key table with insert, search and cost totals.
module sorted_key_table_insert_search_test;

    timeunit 1ns;
    timeprecision 1ps;

    // The table size under test. The shadow table in this bench uses the same figure.
    localparam int CAPACITY = 64;

    // Cycles without any accepted transaction, result or register write before the run is
    // abandoned. The slowest correct run idles the sender in 73 percent of cycles, so long
    // stretches of silence are vanishingly rare. This limit sits far above them.
    localparam int STALL_LIMIT = 1000;

    // A command passes the accept and update states before its result is shown.
    // A few spare cycles at the end catch any stray result strobe.
    localparam int TAIL_CYCLES = 6;

    // Register index that lies beyond the three cost registers. A write to it must be ignored.
    localparam logic [sktis_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Only the first few mismatches are printed. Later ones are counted.
    localparam int REPORT_LIMIT = 10;

    // Kinds of entry in the list of pending stimulus.
    typedef enum logic [1:0]
    {
        ITEM_CMD,    // one command transaction
        ITEM_CFG,    // one register write, issued only when the block is idle
        ITEM_DRAIN,  // the sender holds off until every expected result has arrived
        ITEM_GAP     // a new sender idling rate takes effect
    } item_kind_t;

    typedef struct
    {
        item_kind_t                      kind;
        logic                            op;
        logic [sktis_pkg::KEY_W-1:0]     key;
        logic [sktis_pkg::CFG_IDX_W-1:0] idx;
        logic [sktis_pkg::CFG_W-1:0]     data;
        int                              gap_pct;
    } bench_item_t;

    // One result as the block should report it.
    typedef struct packed
    {
        logic                          found;
        logic                          table_full;
        logic [sktis_pkg::COUNT_W-1:0] stored_count;
        logic [sktis_pkg::TOTAL_W-1:0] write_count;
        logic [sktis_pkg::TOTAL_W-1:0] flush_count;
        logic [sktis_pkg::TOTAL_W-1:0] fence_count;
    } reply_t;

    // Every input of the block starts at a known value.
    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            start        = 1'b0;
    logic                            opcode       = sktis_pkg::OP_SEARCH;
    logic [sktis_pkg::KEY_W-1:0]     key          = '0;
    logic                            cfg_we       = 1'b0;
    logic [sktis_pkg::CFG_IDX_W-1:0] cfg_index    = sktis_pkg::REG_WRITES;
    logic [sktis_pkg::CFG_W-1:0]     cfg_data     = '0;

    logic                            busy;
    logic                            done;
    logic                            found;
    logic                            table_full;
    logic [sktis_pkg::COUNT_W-1:0]   stored_count;
    logic [sktis_pkg::TOTAL_W-1:0]   write_count;
    logic [sktis_pkg::TOTAL_W-1:0]   flush_count;
    logic [sktis_pkg::TOTAL_W-1:0]   fence_count;

    // Pending stimulus, filled at time zero and consumed by the driver.
    bench_item_t stimulus[$];

    // Results predicted for accepted commands, oldest first.
    reply_t predicted_replies[$];

    // Shadow copy of the block's contents and cost registers. Only the entries below
    // shadow_fill hold meaningful keys.
    logic [sktis_pkg::KEY_W-1:0]   shadow_keys [CAPACITY];
    int                            shadow_fill    = 0;
    logic [sktis_pkg::TOTAL_W-1:0] shadow_writes  = '0;
    logic [sktis_pkg::TOTAL_W-1:0] shadow_flushes = '0;
    logic [sktis_pkg::TOTAL_W-1:0] shadow_fences  = '0;
    logic [sktis_pkg::CFG_W-1:0]   writes_cost    = sktis_pkg::WRITES_RST;
    logic [sktis_pkg::CFG_W-1:0]   flushes_cost   = sktis_pkg::FLUSHES_RST;
    logic [sktis_pkg::CFG_W-1:0]   fences_cost    = sktis_pkg::FENCES_RST;

    // Percentage of cycles in which the sender holds back a command that it could present.
    int sender_gap_pct = 11;

    int fault_count  = 0;
    int stall_cycles = 0;

    // Keys issued so far, so that searches and duplicate inserts can aim at stored keys.
    logic [sktis_pkg::KEY_W-1:0] issued_keys[$];
    int                          inserts_issued = 0;

    sorted_key_table_insert_search
    #(
        .CAPACITY(CAPACITY)
    )
    u_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .key(key),
        .done(done),
        .found(found),
        .table_full(table_full),
        .stored_count(stored_count),
        .write_count(write_count),
        .flush_count(flush_count),
        .fence_count(fence_count),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Applies one command to the shadow table and returns the result that it should produce.
    // An insert goes in front of the first key that is not less than it, so it lands before
    // any equal keys. A refused insert on a full table leaves the table and totals untouched.
    function automatic reply_t apply_command(input logic op,
                                             input logic [sktis_pkg::KEY_W-1:0] k);
        reply_t r;
        int     slot;
        int     j;
        r    = '0;
        slot = 0;
        while (slot < shadow_fill && shadow_keys[slot] < k)
            slot++;
        if (op == sktis_pkg::OP_SEARCH)
        begin
            r.found = (slot < shadow_fill) && (shadow_keys[slot] == k);
        end
        else if (shadow_fill >= CAPACITY)
        begin
            r.table_full = 1'b1;
        end
        else
        begin
            for (j = shadow_fill; j > slot; j--)
                shadow_keys[j] = shadow_keys[j - 1];
            shadow_keys[slot] = k;
            shadow_fill++;
            shadow_writes  = shadow_writes + sktis_pkg::TOTAL_W'(writes_cost);
            shadow_flushes = shadow_flushes + sktis_pkg::TOTAL_W'(flushes_cost);
            shadow_fences  = shadow_fences + sktis_pkg::TOTAL_W'(fences_cost);
        end
        r.stored_count = shadow_fill[sktis_pkg::COUNT_W-1:0];
        r.write_count  = shadow_writes;
        r.flush_count  = shadow_flushes;
        r.fence_count  = shadow_fences;
        return r;
    endfunction

    task automatic add_command(input logic op, input logic [sktis_pkg::KEY_W-1:0] k);
        bench_item_t it;
        it.kind    = ITEM_CMD;
        it.op      = op;
        it.key     = k;
        it.idx     = sktis_pkg::REG_WRITES;
        it.data    = '0;
        it.gap_pct = 0;
        stimulus.push_back(it);
        issued_keys.push_back(k);
        if (op == sktis_pkg::OP_INSERT)
            inserts_issued++;
    endtask

    task automatic add_control(input item_kind_t kind,
                               input logic [sktis_pkg::CFG_IDX_W-1:0] idx,
                               input logic [sktis_pkg::CFG_W-1:0] data, input int gap_pct);
        bench_item_t it;
        it.kind    = kind;
        it.op      = sktis_pkg::OP_SEARCH;
        it.key     = '0;
        it.idx     = idx;
        it.data    = data;
        it.gap_pct = gap_pct;
        stimulus.push_back(it);
    endtask

    // Picks a key that is likely to matter: a stored one, a neighbour of one, a small value
    // that invites duplicates, one with its upper half all ones, or a wholly random 64-bit value.
    function automatic logic [sktis_pkg::KEY_W-1:0] pick_key();
        logic [sktis_pkg::KEY_W-1:0] k;
        int                          sel;
        sel = $urandom_range(0, 5);
        k   = {$urandom, $urandom};
        if (issued_keys.size() != 0 && sel <= 1)
            k = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
        else if (issued_keys.size() != 0 && sel == 2)
            k = issued_keys[$urandom_range(0, issued_keys.size() - 1)]
                + (($urandom_range(0, 1) == 1) ? 64'd1 : -64'd1);
        else if (sel == 3)
            k = sktis_pkg::KEY_W'($urandom_range(0, 15));
        else if (sel == 4)
            k = {32'hFFFF_FFFF, $urandom};
        return k;
    endfunction

    // A stretch of random commands. Inserts are kept to roughly one in eight, so that the
    // table fills gradually over the run rather than in its first few dozen transactions.
    // Now and then the sender drains the block completely before carrying on.
    task automatic add_random_commands(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 2)
                add_control(ITEM_DRAIN, sktis_pkg::REG_WRITES, '0, 0);
            if ($urandom_range(0, 99) < 13)
                add_command(sktis_pkg::OP_INSERT, pick_key());
            else
                add_command(sktis_pkg::OP_SEARCH, pick_key());
        end
    endtask

    // Writes all three cost registers, plus one write to the spare index that must be ignored.
    task automatic add_cost_setting(input logic [sktis_pkg::CFG_W-1:0] w,
                                    input logic [sktis_pkg::CFG_W-1:0] f,
                                    input logic [sktis_pkg::CFG_W-1:0] c);
        add_control(ITEM_DRAIN, sktis_pkg::REG_WRITES, '0, 0);
        add_control(ITEM_CFG, sktis_pkg::REG_WRITES, w, 0);
        add_control(ITEM_CFG, sktis_pkg::REG_FLUSHES, f, 0);
        add_control(ITEM_CFG, REG_SPARE, sktis_pkg::CFG_W'($urandom_range(0, 15)), 0);
        add_control(ITEM_CFG, sktis_pkg::REG_FENCES, c, 0);
    endtask

    // Driver. A command stays on the ports until the block accepts it, and the prediction is
    // made at the edge that accepts the transaction. Register writes wait until no result is
    // outstanding and no command is presented, which is when the block is idle. Each port is
    // given at most one nonblocking assignment per edge.
    always @(posedge clk)
    begin : driver
        bench_item_t head;
        logic        accepted;
        logic        next_start;
        logic        next_we;
        accepted   = start && !busy;
        next_start = start && !accepted;
        next_we    = 1'b0;
        if (accepted)
            predicted_replies.push_back(apply_command(opcode, key));
        if (rst_n && !next_start && stimulus.size() != 0)
        begin
            head = stimulus[0];
            case (head.kind)
                ITEM_CMD:
                begin
                    if ($urandom_range(0, 99) >= sender_gap_pct)
                    begin
                        void'(stimulus.pop_front());
                        next_start = 1'b1;
                        opcode    <= head.op;
                        key       <= head.key;
                    end
                end
                ITEM_CFG:
                begin
                    if (!accepted && predicted_replies.size() == 0)
                    begin
                        void'(stimulus.pop_front());
                        next_we    = 1'b1;
                        cfg_index <= head.idx;
                        cfg_data  <= head.data;
                        // The write lands at the next edge, before any later command can
                        // be accepted, so the shadow registers may follow it now.
                        if (head.idx == sktis_pkg::REG_WRITES)
                            writes_cost = head.data;
                        else if (head.idx == sktis_pkg::REG_FLUSHES)
                            flushes_cost = head.data;
                        else if (head.idx == sktis_pkg::REG_FENCES)
                            fences_cost = head.data;
                    end
                end
                ITEM_DRAIN:
                begin
                    if (predicted_replies.size() == 0)
                        void'(stimulus.pop_front());
                end
                default:
                begin
                    sender_gap_pct = head.gap_pct;
                    void'(stimulus.pop_front());
                end
            endcase
        end
        start  <= next_start;
        cfg_we <= next_we;
    end

    // Monitor. A result is shown for one cycle only, so it is taken at the edge that closes
    // that cycle and compared with the oldest prediction. The monitor also counts cycles with
    // no accepted command, no result and no register write, for the watchdog.
    always @(posedge clk)
    begin : monitor
        reply_t got;
        reply_t want;
        if (rst_n)
        begin
            if (done)
            begin
                got.found        = found;
                got.table_full   = table_full;
                got.stored_count = stored_count;
                got.write_count  = write_count;
                got.flush_count  = flush_count;
                got.fence_count  = fence_count;
                if (predicted_replies.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("result with no transaction outstanding: found=%b full=%b",
                                 got.found, got.table_full);
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (got !== want)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                        begin
                            $display("mismatch: expected found=%b full=%b count=%0d",
                                     want.found, want.table_full, want.stored_count);
                            $display("  writes=%h flushes=%h fences=%h",
                                     want.write_count, want.flush_count, want.fence_count);
                            $display("  actual found=%b full=%b count=%0d",
                                     got.found, got.table_full, got.stored_count);
                            $display("  writes=%h flushes=%h fences=%h",
                                     got.write_count, got.flush_count, got.fence_count);
                        end
                    end
                end
            end
            if ((start && !busy) || done || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial
    begin
        // Directed opening with the cost registers at their reset values. Searches of an
        // empty table must miss; the extreme keys go in twice each so that duplicates are
        // stored; near misses around stored keys must not be reported as found.
        add_command(sktis_pkg::OP_SEARCH, 64'h0);
        add_command(sktis_pkg::OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF);
        add_command(sktis_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        add_command(sktis_pkg::OP_INSERT, 64'h0);
        add_command(sktis_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        add_command(sktis_pkg::OP_INSERT, 64'h0);
        add_command(sktis_pkg::OP_SEARCH, 64'h0);
        add_command(sktis_pkg::OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF);
        add_command(sktis_pkg::OP_SEARCH, 64'h1);
        add_command(sktis_pkg::OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFE);
        add_command(sktis_pkg::OP_INSERT, 64'h8000_0000_0000_0000);
        add_command(sktis_pkg::OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
        add_command(sktis_pkg::OP_SEARCH, 64'h8000_0000_0000_0000);
        add_command(sktis_pkg::OP_SEARCH, 64'h7FFF_FFFF_FFFF_FFFE);
        add_command(sktis_pkg::OP_INSERT, 64'h5555_5555_5555_5555);
        add_command(sktis_pkg::OP_SEARCH, 64'hAAAA_AAAA_AAAA_AAAA);
        add_command(sktis_pkg::OP_SEARCH, 64'h5555_5555_5555_5555);

        // First random phase: every cost at its maximum, the sender idling now and then.
        add_cost_setting(4'hF, 4'hF, 4'hF);
        add_random_commands(250);

        // Second random phase: every cost at zero, the sender idling most of the time.
        add_cost_setting(4'h0, 4'h0, 4'h0);
        add_control(ITEM_GAP, sktis_pkg::REG_WRITES, '0, 73);
        add_random_commands(250);

        // Third phase at full rate with random costs. The table is topped up first, so that
        // a good share of the inserts here hit a full table and must be refused.
        add_cost_setting(sktis_pkg::CFG_W'($urandom_range(1, 14)),
                         sktis_pkg::CFG_W'($urandom_range(1, 14)),
                         sktis_pkg::CFG_W'($urandom_range(1, 14)));
        add_control(ITEM_GAP, sktis_pkg::REG_WRITES, '0, 0);
        while (inserts_issued < CAPACITY + 3)
            add_command(sktis_pkg::OP_INSERT, pick_key());
        add_random_commands(230);

        // Reset is held at the start and never asserted again.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while ((stimulus.size() != 0 || start || predicted_replies.size() != 0)
               && stall_cycles < STALL_LIMIT)
            @(posedge clk);

        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("sorted_key_table_insert_search_test: done, errors");
        end
        else
        begin
            repeat (TAIL_CYCLES) @(posedge clk);
            if (fault_count == 0 && predicted_replies.size() == 0)
                $display("sorted_key_table_insert_search_test: done, clean");
            else
                $display("sorted_key_table_insert_search_test: done, errors");
        end
        $finish;
    end

endmodule
